[hw/rtl/cfws_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package cfws_pkg;

  // Field widths
  localparam int ActionW   = 2;
  localparam int WordW     = 32;
  localparam int StatusW   = 2;
  localparam int PositionW = 4;
  localparam int OccW      = 5;

  // Packed stream widths, rounded up to whole bytes
  localparam int InBits  = ActionW + WordW;
  localparam int InW     = ((InBits + 7) / 8) * 8;
  localparam int OutBits = StatusW + WordW + PositionW + OccW;
  localparam int OutW    = ((OutBits + 7) / 8) * 8;

  // Action codes
  localparam logic [ActionW-1:0] ACT_PUSH   = 2'd0;
  localparam logic [ActionW-1:0] ACT_POP    = 2'd1;
  localparam logic [ActionW-1:0] ACT_SEARCH = 2'd2;

  // Status codes
  localparam logic [StatusW-1:0] STAT_OK       = 2'd0;
  localparam logic [StatusW-1:0] STAT_FULL     = 2'd1;
  localparam logic [StatusW-1:0] STAT_EMPTY    = 2'd2;
  localparam logic [StatusW-1:0] STAT_NOTFOUND = 2'd3;

  localparam logic signed [WordW-1:0] WORD_EMPTY = -32'sd1;

  typedef logic [InW-1:0]  in_bus_t;
  typedef logic [OutW-1:0] out_bus_t;

endpackage
`default_nettype wire

[hw/rtl/circular_fifo_with_search.sv]
`timescale 1ns / 1ps
`default_nettype none
// Result path, accept to m_tvalid: push and full/empty/no-op go from accept straight to the done state,
// pop through the pop state, search through the scan state comparing k entries (1..occupancy).
// One transaction in flight, as s_tready is high only in idle; a search walks the single read port
// of the storage RAM, one entry per cycle.
// A finished result waits in the output register while the next transaction is taken.
// Synchronous active-high reset clears head, write index, count and the handshake; RAM is not cleared.
module circular_fifo_with_search #(
  parameter int DEPTH = 16
) (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    s_tvalid,
  output logic                   s_tready,
  input  wire cfws_pkg::in_bus_t s_tdata,   // [1:0] action, [33:2] value
  output logic                   m_tvalid,
  input  wire                    m_tready,
  output cfws_pkg::out_bus_t     m_tdata    // [1:0] status, [33:2] data, [37:34] position,
                                            // [42:38] occupancy
);
  import cfws_pkg::*;

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_POP  = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  function automatic logic [IW-1:0] nxt(input logic [IW-1:0] i);
    nxt = (i == IW'(DEPTH - 1)) ? '0 : i + 1'b1;
  endfunction

  logic [1:0]    state;
  logic [IW-1:0] head;
  logic [IW-1:0] wr;
  logic [CW-1:0] count;
  logic [CW-1:0] scan_left;
  logic [IW-1:0] scan_idx;
  logic signed [WordW-1:0] key;

  // Pending result
  logic [StatusW-1:0]      res_status;
  logic signed [WordW-1:0] res_data;
  logic [PositionW-1:0]    res_pos;
  logic [OccW-1:0]         res_occ;

  // Storage RAM
  logic signed [WordW-1:0] mem [DEPTH];
  logic signed [WordW-1:0] rd_data;
  logic                    mem_we;
  logic                    mem_re;
  logic [IW-1:0]           mem_raddr;

  logic                    s_acc;
  logic [ActionW-1:0]      in_action;
  logic signed [WordW-1:0] in_value;
  logic                    full;
  logic                    empty;
  logic                    hit;

  assign s_tready  = (state == S_IDLE);
  assign s_acc     = s_tvalid && s_tready;
  assign in_action = s_tdata[ActionW-1:0];
  assign in_value  = s_tdata[ActionW +: WordW];
  assign full      = (count == CW'(DEPTH));
  assign empty     = (count == '0);
  assign hit       = (rd_data == key);

  // RAM port control
  always_comb begin
    mem_we    = s_acc && (in_action == ACT_PUSH) && !full;
    mem_re    = (s_acc && !empty && ((in_action == ACT_POP) || (in_action == ACT_SEARCH)))
             || ((state == S_SCAN) && !hit && (scan_left > CW'(1)));
    mem_raddr = (state == S_SCAN) ? nxt(scan_idx) : head;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr] <= in_value;
    end
    if (mem_re) begin
      rd_data <= mem[mem_raddr];
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      head     <= '0;
      wr       <= '0;
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      // Result taken and no new one loaded this cycle
      if (m_tvalid && m_tready && (state != S_DONE)) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_acc) begin
            key     <= in_value;
            res_pos <= '0;
            case (in_action)
              ACT_PUSH: begin
                res_data <= '0;
                state    <= S_DONE;
                if (full) begin
                  res_status <= STAT_FULL;
                  res_occ    <= OccW'(count);
                end else begin
                  res_status <= STAT_OK;
                  wr         <= nxt(wr);
                  count      <= count + 1'b1;
                  res_occ    <= OccW'(count + 1'b1);
                end
              end
              ACT_POP: begin
                if (empty) begin
                  res_status <= STAT_EMPTY;
                  res_data   <= WORD_EMPTY;
                  res_occ    <= OccW'(count);
                  state      <= S_DONE;
                end else begin
                  res_status <= STAT_OK;
                  state      <= S_POP;
                end
              end
              ACT_SEARCH: begin
                res_data <= '0;
                res_occ  <= OccW'(count);
                if (empty) begin
                  res_status <= STAT_NOTFOUND;
                  state      <= S_DONE;
                end else begin
                  res_status <= STAT_OK;
                  scan_idx   <= head;
                  scan_left  <= count;
                  state      <= S_SCAN;
                end
              end
              default: begin
                res_status <= STAT_OK;
                res_data   <= '0;
                res_occ    <= OccW'(count);
                state      <= S_DONE;
              end
            endcase
          end
        end
        S_POP: begin
          res_data <= rd_data;
          head     <= nxt(head);
          count    <= count - 1'b1;
          res_occ  <= OccW'(count - 1'b1);
          state    <= S_DONE;
        end
        S_SCAN: begin
          // One stored entry compared per cycle, from the head onward
          if (hit) begin
            res_pos <= PositionW'(scan_idx);
            state   <= S_DONE;
          end else if (scan_left == CW'(1)) begin
            res_status <= STAT_NOTFOUND;
            state      <= S_DONE;
          end else begin
            scan_idx  <= nxt(scan_idx);
            scan_left <= scan_left - 1'b1;
          end
        end
        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= out_bus_t'({res_occ, res_pos, res_data, res_status});
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("occupancy above depth");

  a_push_count: assert property (@(posedge clk) disable iff (rst)
    (s_acc && (in_action == ACT_PUSH) && !full) |=> (count == $past(count) + 1'b1))
    else $error("push did not raise occupancy");

  a_pop_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_POP) |=> (count == $past(count) - 1'b1) && (state == S_DONE))
    else $error("pop did not lower occupancy");

  a_scan_live: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (scan_left != '0) && !empty)
    else $error("scan with nothing left to compare");

endmodule
`default_nettype wire
